/* rtl/core/integer_to_ascii_radix_defines.svh */
// ---------------------------------------------------------------------------
// integer_to_ascii_radix assertion macros
// shared property forms for the checker
// ---------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_RADIX_DEFINES_SVH
`define INTEGER_TO_ASCII_RADIX_DEFINES_SVH

// same-cycle implication, masked in reset
`define ITA_ASSERT_IMPL(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, masked in reset
`define ITA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

// next-cycle implication, live through reset
`define ITA_ASSERT_NEXT_ALWAYS(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) (pre) |=> (post)) \
    else $error(msg);

`endif

/* rtl/core/ita_pkg.sv */
// ---------------------------------------------------------------------------
// ita_pkg
// shared constants, types and digit encoding for integer_to_ascii_radix
// ---------------------------------------------------------------------------
package ita_pkg;

  localparam int VALUE_WIDTH = 64;
  localparam int IN_W        = 64;
  localparam int FMT_W       = 2;
  localparam int CHAR_W      = 8;

  localparam int CONV_STEPS  = (VALUE_WIDTH + 3) / 4;
  localparam int PAD_W       = CONV_STEPS * 4;
  localparam int DEC_DIGITS  = ((VALUE_WIDTH * 1233) >> 12) + 1;
  localparam int DIG_W       = DEC_DIGITS * 4;
  localparam int CNT_W       = $clog2(DEC_DIGITS + 1);
  localparam int STEP_W      = $clog2(CONV_STEPS);

  localparam int Q_DEPTH     = 2;
  localparam int Q_AW        = $clog2(Q_DEPTH);

  localparam logic [FMT_W-1:0] FMT_DEC       = 2'd0;
  localparam logic [FMT_W-1:0] FMT_HEX_LOWER = 2'd1;
  localparam logic [FMT_W-1:0] FMT_HEX_UPPER = 2'd2;

  localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;

  typedef struct packed {
    logic [PAD_W-1:0] value;
    logic             is_hex;
    logic             upper;
  } ita_entry_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
    logic [CHAR_W-1:0] base;
    if (d < 4'd10) begin
      return CHAR_ZERO + {4'b0000, d};
    end
    base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
    return base + {4'b0000, d} - 8'd10;
  endfunction

endpackage

/* rtl/core/ita_if.sv */
// ---------------------------------------------------------------------------
// ita_if
// valid/ready channel interfaces for values in and characters out
// ---------------------------------------------------------------------------
interface ita_in_if;
  import ita_pkg::*;

  logic             valid;
  logic             ready;
  logic [IN_W-1:0]  value;
  logic [FMT_W-1:0] format;

  modport source (output valid, output value, output format, input ready);
  modport sink (input valid, input value, input format, output ready);
endinterface

interface ita_out_if;
  import ita_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;

  modport source (output valid, output character, output last, input ready);
  modport sink (input valid, input character, input last, output ready);
endinterface

/* rtl/core/integer_to_ascii_radix.sv */
// ---------------------------------------------------------------------------
// integer_to_ascii_radix
// unsigned binary value to ASCII decimal or hexadecimal text
// ---------------------------------------------------------------------------
// in_ch takes one transaction per value: value plus format (decimal, lower-case
// hex, upper-case hex; the unused code converts as decimal). out_ch gives one
// transaction per character, most significant digit first, with last set on
// the final one; zero gives a single '0'.
// A two-entry queue sits behind in_ch, so up to two values are taken while
// the converter is busy. Decimal runs through a shift-and-add-3 unit at four
// bits per cycle; hex needs no conversion. Each value then walks all 20
// digits of the digit register: leading zero digits are dropped at one per
// cycle, and characters leave at one per cycle from an output register while
// out_ch is ready. A stalled out_ch holds its character; the digit walk waits
// at the next digit to send, and in_ch keeps accepting until the queue is
// full. Synchronous reset empties the queue and drops any partly sent value.
// ---------------------------------------------------------------------------
module integer_to_ascii_radix (
  input  logic      clk,
  input  logic      rst_n,
  ita_in_if.sink    in_ch,
  ita_out_if.source out_ch
);
  import ita_pkg::*;

  logic       q_valid;
  logic       q_ready;
  ita_entry_t q_entry;

  ita_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_entry (q_entry)
  );

  ita_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_entry (q_entry),
    .out_ch  (out_ch)
  );

endmodule

/* rtl/core/ita_front.sv */
// ---------------------------------------------------------------------------
// ita_front
// accepts values, decodes the format and holds them in a two-entry queue
// ---------------------------------------------------------------------------
module ita_front (
  input  logic                clk,
  input  logic                rst_n,
  ita_in_if.sink              in_ch,
  output logic                q_valid,
  input  logic                q_ready,
  output ita_pkg::ita_entry_t q_entry
);
  import ita_pkg::*;

  ita_entry_t      q_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r;
  logic [Q_AW-1:0] rd_ptr_r;
  logic [Q_AW:0]   count_r;
  logic [Q_AW:0]   count_nxt;
  ita_entry_t      entry_in;
  logic            push;
  logic            pop;

  always_comb begin
    entry_in.value  = PAD_W'(in_ch.value[VALUE_WIDTH-1:0]);
    entry_in.is_hex = 1'b0;
    entry_in.upper  = 1'b0;
    case (in_ch.format)
      FMT_HEX_LOWER: begin
        entry_in.is_hex = 1'b1;
      end
      FMT_HEX_UPPER: begin
        entry_in.is_hex = 1'b1;
        entry_in.upper  = 1'b1;
      end
      default: begin
        entry_in.is_hex = 1'b0;
      end
    endcase
  end

  assign in_ch.ready = (count_r != (Q_AW + 1)'(Q_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (count_r != '0);
  assign pop         = q_valid && q_ready;
  assign q_entry     = q_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    case ({push, pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= entry_in;
    end
  end

endmodule

/* rtl/core/ita_back.sv */
// ---------------------------------------------------------------------------
// ita_back
// binary to digits to characters, one character per cycle unless stalled
// ---------------------------------------------------------------------------
module ita_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  output logic                q_ready,
  input  ita_pkg::ita_entry_t q_entry,
  ita_out_if.source           out_ch
);
  import ita_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0]        state_r,   state_nxt;
  logic [STEP_W-1:0] step_r,    step_nxt;
  logic [CNT_W-1:0]  ndig_r,    ndig_nxt;
  logic              upper_r,   upper_nxt;
  logic              started_r, started_nxt;
  logic [PAD_W-1:0]  bin_r,     bin_nxt;
  logic [DIG_W-1:0]  bcd_r,     bcd_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [CHAR_W-1:0] char_r,    char_nxt;
  logic              last_r,    last_nxt;

  logic [DIG_W+PAD_W-1:0] dabble_w;
  logic [3:0]             top_digit;
  logic                   slot_free;
  logic                   final_digit;

  function automatic logic [DIG_W+PAD_W-1:0] dabble(input logic [DIG_W+PAD_W-1:0] x);
    logic [DIG_W+PAD_W-1:0] y;
    y = x;
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (y[PAD_W+4*i +: 4] >= 4'd5) begin
        y[PAD_W+4*i +: 4] = y[PAD_W+4*i +: 4] + 4'd3;
      end
    end
    return y << 1;
  endfunction

  always_comb begin
    dabble_w = {bcd_r, bin_r};
    for (int j = 0; j < 4; j++) begin
      dabble_w = dabble(dabble_w);
    end
  end

  assign top_digit   = bcd_r[DIG_W-1 -: 4];
  assign slot_free   = !out_valid_r || out_ch.ready;
  assign final_digit = (ndig_r == CNT_W'(1));
  assign q_ready     = (state_r == ST_IDLE);

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    ndig_nxt      = ndig_r;
    upper_nxt     = upper_r;
    started_nxt   = started_r;
    bin_nxt       = bin_r;
    bcd_nxt       = bcd_r;
    char_nxt      = char_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          upper_nxt   = q_entry.upper;
          started_nxt = 1'b0;
          ndig_nxt    = CNT_W'(DEC_DIGITS);
          if (q_entry.is_hex) begin
            bcd_nxt   = DIG_W'(q_entry.value);
            state_nxt = ST_EMIT;
          end else begin
            bin_nxt   = q_entry.value;
            bcd_nxt   = '0;
            step_nxt  = STEP_W'(CONV_STEPS - 1);
            state_nxt = ST_CONV;
          end
        end
      end
      ST_CONV: begin
        {bcd_nxt, bin_nxt} = dabble_w;
        if (step_r == '0) begin
          state_nxt = ST_EMIT;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      ST_EMIT: begin
        if (!started_r && top_digit == 4'd0 && !final_digit) begin
          bcd_nxt  = bcd_r << 4;
          ndig_nxt = ndig_r - 1'b1;
        end else if (slot_free) begin
          out_valid_nxt = 1'b1;
          char_nxt      = digit_char(top_digit, upper_r);
          last_nxt      = final_digit;
          started_nxt   = 1'b1;
          bcd_nxt       = bcd_r << 4;
          ndig_nxt      = ndig_r - 1'b1;
          if (final_digit) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    step_r    <= step_nxt;
    ndig_r    <= ndig_nxt;
    upper_r   <= upper_nxt;
    started_r <= started_nxt;
    bin_r     <= bin_nxt;
    bcd_r     <= bcd_nxt;
    char_r    <= char_nxt;
    last_r    <= last_nxt;
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.character = char_r;
  assign out_ch.last      = last_r;

endmodule

/* rtl/core/ita_checker.sv */
// ---------------------------------------------------------------------------
// ita_checker
// port-level checks on the character stream of integer_to_ascii_radix
// ---------------------------------------------------------------------------
`include "integer_to_ascii_radix_defines.svh"

module ita_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic [ita_pkg::CHAR_W-1:0] out_character,
  input logic                       out_last
);
  import ita_pkg::*;

  logic first_r;
  logic is_digit;
  logic is_lower;
  logic is_upper;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_r <= 1'b1;
    end else if (out_valid && out_ready) begin
      first_r <= out_last;
    end
  end

  assign is_digit = (out_character >= CHAR_ZERO) && (out_character <= CHAR_ZERO + 8'd9);
  assign is_lower = (out_character >= CHAR_LOWER_A) && (out_character <= CHAR_LOWER_A + 8'd5);
  assign is_upper = (out_character >= CHAR_UPPER_A) && (out_character <= CHAR_UPPER_A + 8'd5);

  `ITA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_character) && $stable(out_last), "character changed or dropped while stalled")
  `ITA_ASSERT_NEXT_ALWAYS(a_reset_quiet, !rst_n, !out_valid, "character offered straight after reset")
  `ITA_ASSERT_IMPL(a_char_legal, out_valid, is_digit || is_lower || is_upper, "character outside the digit set")
  `ITA_ASSERT_IMPL(a_no_lead_zero, out_valid && first_r && out_character == CHAR_ZERO, out_last, "leading zero in a multi-digit value")

endmodule

bind integer_to_ascii_radix ita_checker u_ita_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_character (out_ch.character),
  .out_last      (out_ch.last)
);

/* tb/sv/integer_to_ascii_radix_check.sv */
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_check
// watches both channels, works out the ASCII digits of every accepted value
// and compares each outgoing character transaction against them in order
// ----------------------------------------------------------------------------
module integer_to_ascii_radix_check (
  input  logic clk,
  input  logic rst_n,
  ita_in_if    in_ch,
  ita_out_if   out_ch,
  output int   mismatch_count,
  output int   chars_pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import ita_pkg::*;

  localparam int DIGIT_LIMIT = 20;

  typedef struct packed {
    logic [CHAR_W-1:0] character;
    logic              last;
  } ascii_char_t;

  ascii_char_t awaited_chars [$];
  int          errors = 0;
  int          pending = 0;

  assign mismatch_count = errors;
  assign chars_pending  = pending;

  function automatic void predict_digits(input logic [IN_W-1:0] raw,
                                         input logic [FMT_W-1:0] fmt);
    logic [63:0]       v;
    logic [63:0]       radix;
    logic [CHAR_W-1:0] alpha;
    logic [3:0]        d;
    logic [CHAR_W-1:0] digits [$];
    int                n;
    v = raw;
    if (VALUE_WIDTH < 64) begin
      v = v & ((64'd1 << VALUE_WIDTH) - 64'd1);
    end
    radix = (fmt == FMT_HEX_LOWER || fmt == FMT_HEX_UPPER) ? 64'd16 : 64'd10;
    alpha = (fmt == FMT_HEX_UPPER) ? CHAR_W'("A") : CHAR_W'("a");
    n = 0;
    // least significant digit first, so each new digit goes to the front
    do begin
      d = 4'(v % radix);
      if (d < 4'd10) begin
        digits.push_front(CHAR_W'("0") + CHAR_W'(d));
      end else begin
        digits.push_front(alpha + CHAR_W'(d) - CHAR_W'(10));
      end
      v = v / radix;
      n++;
    end while (v != 64'd0 && n < DIGIT_LIMIT);
    foreach (digits[i]) begin
      awaited_chars.push_back('{character: digits[i], last: (i == digits.size() - 1)});
    end
  endfunction

  always @(posedge clk) begin
    ascii_char_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        predict_digits(in_ch.value, in_ch.format);
      end
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_chars.size() == 0) begin
          $error("character: expected none, actual %h", out_ch.character);
          errors++;
        end else begin
          want = awaited_chars.pop_front();
          if (out_ch.character !== want.character) begin
            $error("character: expected %h, actual %h", want.character, out_ch.character);
            errors++;
          end
          if (out_ch.last !== want.last) begin
            $error("last: expected %b, actual %b", want.last, out_ch.last);
            errors++;
          end
        end
      end
    end
    pending <= awaited_chars.size();
  end

endmodule

/* tb/sv/integer_to_ascii_radix_test.sv */
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_test
// drives values in all four format codes through integer_to_ascii_radix:
// a directed set of edge values, then random values under varying idling on
// both channels; the checker beside the block judges every character
// ----------------------------------------------------------------------------
module integer_to_ascii_radix_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ita_pkg::*;

  localparam logic [FMT_W-1:0] FMT_SPARE = 2'd3;
  localparam int N_DIRECTED = 22;
  localparam int N_RANDOM_PER_PHASE = 30;
  localparam int SETTLE_CYCLES = 64;
  localparam int WATCHDOG_CYCLES = 400_000;

  typedef struct packed {
    logic [IN_W-1:0]  value;
    logic [FMT_W-1:0] format;
  } value_item_t;

  localparam value_item_t EDGE_VALUES [N_DIRECTED] = '{
    '{64'd0, FMT_DEC},
    '{64'd0, FMT_HEX_LOWER},
    '{64'd0, FMT_HEX_UPPER},
    '{64'd0, FMT_SPARE},
    '{64'hFFFF_FFFF_FFFF_FFFF, FMT_DEC},
    '{64'hFFFF_FFFF_FFFF_FFFF, FMT_HEX_LOWER},
    '{64'hFFFF_FFFF_FFFF_FFFF, FMT_HEX_UPPER},
    '{64'hFFFF_FFFF_FFFF_FFFF, FMT_SPARE},
    '{64'd1, FMT_DEC},
    '{64'd9, FMT_DEC},
    '{64'd10, FMT_DEC},
    '{64'd15, FMT_HEX_LOWER},
    '{64'd16, FMT_HEX_UPPER},
    '{64'h8AC7_2304_89E8_0000, FMT_DEC},
    '{64'h8AC7_2304_89E7_FFFF, FMT_DEC},
    '{64'h8000_0000_0000_0000, FMT_DEC},
    '{64'h0123_4567_89AB_CDEF, FMT_HEX_LOWER},
    '{64'hFEDC_BA98_7654_3210, FMT_HEX_UPPER},
    '{64'h0000_0000_ABCD_EF00, FMT_HEX_UPPER},
    '{64'h0000_0000_00AB_CDEF, FMT_HEX_LOWER},
    '{64'd12345, FMT_SPARE},
    '{64'hAAAA_AAAA_5555_5555, FMT_DEC}
  };

  logic clk;
  logic rst_n;
  int   send_gap_pct;
  int   recv_stall_pct;
  int   mismatch_count;
  int   chars_pending;

  ita_in_if  in_ch ();
  ita_out_if out_ch ();

  integer_to_ascii_radix u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  integer_to_ascii_radix_check u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .mismatch_count (mismatch_count),
    .chars_pending  (chars_pending)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // receiver side
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic send_value(input logic [IN_W-1:0] v, input logic [FMT_W-1:0] f);
    while ($urandom_range(99) < send_gap_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.value  <= v;
    in_ch.format <= f;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic drain_chars();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (chars_pending != 0);
  endtask

  initial begin
    logic [IN_W-1:0]  v;
    logic [FMT_W-1:0] f;
    int               bits;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.value    = '0;
    in_ch.format   = FMT_DEC;
    send_gap_pct   = 12;
    recv_stall_pct = 81;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_gap_pct   = 12;
          recv_stall_pct = 81;
          foreach (EDGE_VALUES[i]) begin
            send_value(EDGE_VALUES[i].value, EDGE_VALUES[i].format);
          end
        end
        1: begin
          send_gap_pct   = 81;
          recv_stall_pct = 12;
        end
        default: begin
          send_gap_pct   = 0;
          recv_stall_pct = 0;
        end
      endcase
      repeat (N_RANDOM_PER_PHASE) begin
        v = {$urandom, $urandom};
        case ($urandom_range(7))
          0: v = '0;
          1: v = '1;
          2: v = v;
          default: begin
            bits = $urandom_range(64, 1);
            v = v >> (64 - bits);
          end
        endcase
        f = ($urandom_range(9) == 0) ? FMT_SPARE : FMT_W'($urandom_range(2));
        send_value(v, f);
      end
      // hold off new values until every character so far has come out
      drain_chars();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && chars_pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #(WATCHDOG_CYCLES * 12);
    $display("status: fail");
    $finish;
  end

endmodule
